// ===== rtl/core/cpba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types and constants of the contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

    // bitmap memory word: one bit per page, 1 = busy
    localparam int WORD_BITS = 32;
    localparam int OFF_W     = 5;

    // field widths
    localparam int PAGE_W  = 36;
    localparam int COUNT_W = 11;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    localparam logic [COUNT_W-1:0] PAGES_RESET = 11'd1024;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_DOUBLE  = 2'd3
    } status_t;

    // outcome of evaluating one bitmap word during the first-fit scan
    typedef struct packed {
        logic               hit;
        logic [OFF_W-1:0]   pos;
        logic [COUNT_W-1:0] run_out;
    } scan_res_t;

endpackage : cpba_pkg
`default_nettype wire

// ===== rtl/core/cpba_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_scan
// Evaluates one bitmap word for the first-fit search: free-run length at
// every bit, first bit where the run reaches the requested count.
// ----------------------------------------------------------------------------
module cpba_scan #(
    parameter int AW = 5
) (
    input  wire logic [cpba_pkg::WORD_BITS-1:0]  word,
    input  wire logic [AW-1:0]                   word_addr,
    input  wire logic [cpba_pkg::COUNT_W-1:0]    run_in,
    input  wire logic [cpba_pkg::COUNT_W-1:0]    count,
    input  wire logic [AW+cpba_pkg::OFF_W:0]     limit,
    output cpba_pkg::scan_res_t                  res
);
    import cpba_pkg::*;

    localparam int LIM_W = AW + OFF_W + 1;

    logic [COUNT_W:0]   run_arr [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;

    // run length at bit j: from the last busy bit at or below j, or
    // carried in from earlier words when the prefix is all free
    always_comb begin
        logic seen;
        int   lb;
        for (int j = 0; j < WORD_BITS; j++) begin
            seen = 1'b0;
            lb   = 0;
            for (int k = 0; k <= j; k++) begin
                if (word[k]) begin
                    seen = 1'b1;
                    lb   = k;
                end
            end
            if (seen) begin
                run_arr[j] = (COUNT_W+1)'(j - lb);
            end else begin
                run_arr[j] = {1'b0, run_in} + (COUNT_W+1)'(j + 1);
            end
            hit_vec[j] = (LIM_W'({1'b0, word_addr, OFF_W'(j)}) < limit)
                      && (run_arr[j] >= {1'b0, count});
        end
    end

    always_comb begin
        res.hit     = |hit_vec;
        res.pos     = '0;
        res.run_out = run_arr[WORD_BITS-1][COUNT_W-1:0];
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                res.pos = OFF_W'(j);
            end
        end
    end

endmodule : cpba_scan
`default_nettype wire

// ===== rtl/core/contiguous_page_bitmap_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_core
// First-fit contiguous page allocator over a busy bitmap held in block RAM.
// ----------------------------------------------------------------------------
// The busy map lives in a RAM of 32-page words (one read and one write port,
// registered read). One request is handled at a time. An allocate streams
// the map from word 0, one word per cycle, and stops at the first free run of
// page_count pages; it then read-modify-writes the words of that run. The
// scan reads at most ceil(active_pages/32) words. A free checks every word of
// the run, then clears them in a second pass; a double free stops the check
// early. A zero-count or oversized allocate is answered from the decode state,
// a range error or a zero-count free from the bound check, without reading the
// map. The result word shows up in the same cycle as the next request can be
// taken. After reset the RAM is swept to zero, one word per cycle; no request
// word is taken during that sweep, but configuration writes are. The result
// word sits in an output register, so the next request can enter while it
// waits. Configuration writes must be made while the block is idle.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_core #(
    parameter int POOL_PAGES = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [cpba_pkg::PAGE_W-1:0]       cfg_wdata,
    // request words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [cpba_pkg::COUNT_W-1:0]      s_page_count,
    input  wire logic [cpba_pkg::PAGE_W-1:0]       s_page_number,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [cpba_pkg::PAGE_W-1:0]            m_first_page
);
    import cpba_pkg::*;

    localparam int DEPTH = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IX_W  = AW + OFF_W;                       // page index
    localparam int LIM_W = IX_W + 1;                         // page count in pool
    localparam int SW    = ((IX_W > COUNT_W) ? IX_W : COUNT_W) + 1;

    typedef enum logic [3:0] {
        S_CLEAR,    // post-reset RAM sweep
        S_IDLE,
        S_DECODE,
        S_BOUND,    // free range check
        S_SCAN,     // first-fit search
        S_MARK,     // set busy bits of the found run
        S_CHECK,    // free: all pages busy?
        S_FREE,     // free: clear the run
        S_DONE
    } state_t;

    // ---------------- bitmap RAM ----------------
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic [AW-1:0]        mem_ra;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // ---------------- registers ----------------
    state_t               state_reg, state_next;
    logic [PAGE_W-1:0]    base_reg, base_next;
    logic [COUNT_W-1:0]   pages_reg, pages_next;
    logic [AW-1:0]        addr_reg, addr_next;          // next word to read
    logic                 issue_done_reg, issue_done_next;
    logic                 pend_reg, pend_next;          // read data valid
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic                 m_valid_reg, m_valid_next;

    // payload, no reset
    logic                 op_reg, op_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [PAGE_W-1:0]    local_reg, local_next;
    logic                 below_reg, below_next;
    logic [COUNT_W-1:0]   run_reg, run_next;
    logic [IX_W-1:0]      lo_reg, lo_next;
    logic [IX_W-1:0]      hi_reg, hi_next;
    status_t              res_status_reg, res_status_next;
    logic [PAGE_W-1:0]    res_first_reg, res_first_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [PAGE_W-1:0]    m_first_reg, m_first_next;

    // ---------------- derived values ----------------
    logic [LIM_W-1:0]     limit;
    logic [LIM_W-1:0]     lim_m1;
    logic [AW-1:0]        last_word;
    logic [AW-1:0]        lo_word, hi_word, end_word;
    logic [WORD_BITS-1:0] run_mask;
    logic                 walking;
    logic                 rd_en;
    logic [PAGE_W-1:0]    lim36;
    logic                 range_err;
    logic [SW-1:0]        start_full;
    logic [SW-1:0]        hi_full;
    logic [IX_W-1:0]      hit_idx;
    scan_res_t            scan_res;

    // effective pool size: min(pool_pages, POOL_PAGES)
    always_comb begin
        if (32'(pages_reg) > POOL_PAGES) begin
            limit = LIM_W'(POOL_PAGES);
        end else begin
            limit = LIM_W'(pages_reg);
        end
    end

    assign lim_m1    = limit - LIM_W'(1);
    assign last_word = AW'(lim_m1 >> OFF_W);
    assign lo_word   = lo_reg[IX_W-1:OFF_W];
    assign hi_word   = hi_reg[IX_W-1:OFF_W];
    assign end_word  = (state_reg == S_SCAN) ? last_word : hi_word;
    assign lim36     = PAGE_W'(limit);

    // bits of word pend_addr_reg that fall inside [lo, hi]
    always_comb begin
        logic [WORD_BITS-1:0] mlo, mhi;
        mlo = (pend_addr_reg == lo_word) ? ({WORD_BITS{1'b1}} << lo_reg[OFF_W-1:0])
                                         : {WORD_BITS{1'b1}};
        mhi = (pend_addr_reg == hi_word)
            ? ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - hi_reg[OFF_W-1:0]))
            : {WORD_BITS{1'b1}};
        run_mask = mlo & mhi;
    end

    cpba_scan #(
        .AW (AW)
    ) u_scan (
        .word      (rd_data_reg),
        .word_addr (pend_addr_reg),
        .run_in    (run_reg),
        .count     (cnt_reg),
        .limit     (limit),
        .res       (scan_res)
    );

    // run found ends at hit_idx; it starts count-1 pages earlier
    assign hit_idx    = {pend_addr_reg, scan_res.pos};
    assign start_full = SW'(hit_idx) + SW'(1) - SW'(cnt_reg);
    assign hi_full    = SW'(local_reg[IX_W-1:0]) + SW'(cnt_reg) - SW'(1);

    assign range_err = below_reg || (local_reg > lim36)
                    || (PAGE_W'(cnt_reg) > (lim36 - local_reg));

    assign walking = (state_reg == S_SCAN) || (state_reg == S_MARK)
                  || (state_reg == S_CHECK) || (state_reg == S_FREE);
    assign rd_en   = walking && !issue_done_reg;
    assign mem_ra  = addr_reg;

    // ---------------- next state ----------------
    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        pages_next      = pages_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = rd_en;
        pend_addr_next  = addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        page_next       = page_reg;
        local_next      = local_reg;
        below_next      = below_reg;
        run_next        = run_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        mem_we          = 1'b0;
        mem_wa          = pend_addr_reg;
        mem_wd          = rd_data_reg | run_mask;

        if (cfg_we) begin
            if (cfg_index[0] == CFG_BASE) begin
                base_next = cfg_wdata;
            end else begin
                pages_next = cfg_wdata[COUNT_W-1:0];
            end
        end

        // streaming reads: one word per cycle up to end_word
        if (rd_en) begin
            if (addr_reg == end_word) begin
                issue_done_next = 1'b1;
            end else begin
                addr_next = addr_reg + AW'(1);
            end
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = '0;
                if (addr_reg == AW'(DEPTH - 1)) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    cnt_next   = s_page_count;
                    page_next  = s_page_number;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_first_next = '0;
                below_next     = page_reg < base_reg;
                local_next     = page_reg - base_reg;
                addr_next       = '0;
                issue_done_next = 1'b0;
                pend_next       = 1'b0;
                run_next        = '0;
                if (op_reg == OP_FREE) begin
                    state_next = S_BOUND;
                end else if (cnt_reg == '0 || SW'(cnt_reg) > SW'(limit)) begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_BOUND: begin
                lo_next = local_reg[IX_W-1:0];
                hi_next = hi_full[IX_W-1:0];
                if (range_err) begin
                    res_status_next = STAT_RANGE;
                    state_next      = S_DONE;
                end else if (cnt_reg == '0) begin
                    res_status_next = STAT_OK;
                    state_next      = S_DONE;
                end else begin
                    addr_next       = local_reg[IX_W-1:OFF_W];
                    issue_done_next = 1'b0;
                    pend_next       = 1'b0;
                    state_next      = S_CHECK;
                end
            end
            S_SCAN: begin
                if (pend_reg) begin
                    run_next = scan_res.run_out;
                    if (scan_res.hit) begin
                        lo_next         = start_full[IX_W-1:0];
                        hi_next         = hit_idx;
                        addr_next       = start_full[IX_W-1:OFF_W];
                        issue_done_next = 1'b0;
                        pend_next       = 1'b0;
                        state_next      = S_MARK;
                    end else if (pend_addr_reg == last_word) begin
                        res_status_next = STAT_NOSPACE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_MARK: begin
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wd = rd_data_reg | run_mask;
                    if (pend_addr_reg == hi_word) begin
                        res_status_next = STAT_OK;
                        res_first_next  = base_reg + PAGE_W'(lo_reg);
                        state_next      = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (pend_reg) begin
                    if ((rd_data_reg & run_mask) != run_mask) begin
                        res_status_next = STAT_DOUBLE;
                        state_next      = S_DONE;
                    end else if (pend_addr_reg == hi_word) begin
                        addr_next       = lo_word;
                        issue_done_next = 1'b0;
                        pend_next       = 1'b0;
                        state_next      = S_FREE;
                    end
                end
            end
            S_FREE: begin
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wd = rd_data_reg & ~run_mask;
                    if (pend_addr_reg == hi_word) begin
                        res_status_next = STAT_OK;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = res_first_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            base_reg       <= '0;
            pages_reg      <= PAGES_RESET;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            pages_reg      <= pages_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        op_reg         <= op_next;
        cnt_reg        <= cnt_next;
        page_reg       <= page_next;
        local_reg      <= local_next;
        below_reg      <= below_next;
        run_reg        <= run_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_page = m_first_reg;

    // ---------------- assertions ----------------
    // map is only written by the sweep and the two write-back passes
    a_no_write_when_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_SCAN || state_reg == S_CHECK) |-> !mem_we)
        else $error("bitmap written outside a write pass");

    // a found run spans exactly the requested count
    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && pend_reg && scan_res.hit)
        |=> (SW'(hi_reg) - SW'(lo_reg) + SW'(1) == SW'(cnt_reg)))
        else $error("allocated run length differs from count");

    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK || state_reg == S_CHECK || state_reg == S_FREE)
        |-> (lo_reg <= hi_reg))
        else $error("run bounds inverted");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word raised outside the done state");

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_ready && mem_we))
        else $error("request accepted during the clearing sweep");

endmodule : contiguous_page_bitmap_allocator_core
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the first-fit contiguous page allocator core.
// Request words come from a queue that the main sequence fills: a directed
// opening, then random phases with different pool bases and sizes. A
// bit-level model of the busy map works out the result word of each accepted
// request. The monitor checks each result word in order against that model.
// ----------------------------------------------------------------------------
module tb_top;
    import cpba_pkg::*;

    localparam int POOL_CAP   = 1024;
    localparam int BATCH_LEN  = 40;
    localparam int BATCHES    = 6;
    localparam int PHASES     = 8;
    localparam int HOLD_AT    = 650;   // result count that starts the long stall
    localparam int HOLD_LEN   = 400;   // cycles of the long stall

    typedef struct packed {
        logic               op;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  page;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] first;
    } outcome_t;

    // a run handed out by an allocate, in pool-local page indexes
    typedef struct {
        int start;
        int count;
    } run_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [0:0]          cfg_index     = '0;
    logic [PAGE_W-1:0]   cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_op          = 1'b0;
    logic [COUNT_W-1:0]  s_page_count  = '0;
    logic [PAGE_W-1:0]   s_page_number = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [1:0]          m_status;
    logic [PAGE_W-1:0]   m_first_page;

    always #5 aclk = ~aclk;

    contiguous_page_bitmap_allocator_core #(
        .POOL_PAGES   (POOL_CAP)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_page_count  (s_page_count),
        .s_page_number (s_page_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_first_page  (m_first_page)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    request_t request_q[$];       // request words not yet offered
    outcome_t owed_results[$];    // result words owed by the block, oldest first
    run_t     granted_runs[$];    // runs the model has handed out
    run_t     last_freed;
    bit       have_last     = 1'b0;
    bit       no_idle       = 1'b0;   // both sides run without gaps
    int       mismatch_cnt  = 0;
    int       results_seen  = 0;
    int       hold_left     = 0;
    bit       held_once     = 1'b0;

    // model copy of the busy map and the two registers
    bit                 busy_bits [POOL_CAP];
    logic [PAGE_W-1:0]  base_reg  = '0;
    logic [COUNT_W-1:0] pages_reg = PAGES_RESET;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic int live_pages();
        return (int'(pages_reg) > POOL_CAP) ? POOL_CAP : int'(pages_reg);
    endfunction

    function automatic logic [PAGE_W-1:0] rand36();
        return PAGE_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Model of one request: first-fit allocate, or checked free.
    // The map is only touched on success; a failed free leaves it alone.
    // ------------------------------------------------------------------------
    function automatic outcome_t serve_request(input request_t r);
        outcome_t          o;
        int                lim;
        int                run;
        int                start;
        int                lp;
        logic [PAGE_W:0]   offset;
        bit                clash;
        lim      = live_pages();
        o.status = STAT_NOSPACE;
        o.first  = '0;
        if (r.op == OP_ALLOC) begin
            if (r.count != 0 && int'(r.count) <= lim) begin
                run   = 0;
                start = -1;
                for (int p = 0; p < lim && start < 0; p++) begin
                    run = busy_bits[p] ? 0 : run + 1;
                    if (run == int'(r.count))
                        start = p + 1 - run;
                end
                if (start >= 0) begin
                    for (int k = start; k < start + int'(r.count); k++)
                        busy_bits[k] = 1'b1;
                    o.status = STAT_OK;
                    o.first  = base_reg + PAGE_W'(start);
                    granted_runs.push_back('{start, int'(r.count)});
                end
            end
        end else begin
            // compare without wrap: a page below the base is out of range
            offset = {1'b0, r.page} - {1'b0, base_reg};
            if (r.page < base_reg || offset > lim) begin
                o.status = STAT_RANGE;
            end else begin
                lp = int'(offset);
                if (int'(r.count) > lim - lp) begin
                    o.status = STAT_RANGE;
                end else begin
                    clash = 1'b0;
                    for (int k = lp; k < lp + int'(r.count); k++)
                        if (!busy_bits[k]) clash = 1'b1;
                    if (clash) begin
                        o.status = STAT_DOUBLE;
                    end else begin
                        for (int k = lp; k < lp + int'(r.count); k++)
                            busy_bits[k] = 1'b0;
                        o.status = STAT_OK;
                    end
                end
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Random request: mostly allocates and frees of runs handed out earlier,
    // the rest stray frees (far off, near the pool, below the base, repeats).
    // ------------------------------------------------------------------------
    function automatic request_t make_request();
        request_t r;
        int       lim;
        int       pick;
        int       idx;
        int       cap;
        run_t     g;
        lim     = live_pages();
        r.op    = OP_ALLOC;
        r.page  = rand36();         // ignored on allocate, toggles the bits
        r.count = '0;
        pick    = $urandom_range(99);
        if (pick >= 45 && pick < 83 && granted_runs.size() == 0)
            pick = 0;
        if (pick < 45) begin
            idx = $urandom_range(99);
            cap = (lim < 40) ? lim : 40;
            if (idx < 5)
                r.count = COUNT_W'($urandom_range(1024));
            else if (idx < 10)     // whole pool, or one more than the pool
                r.count = COUNT_W'((lim < POOL_CAP && idx < 8) ? lim + 1 : lim);
            else if (idx < 13)
                r.count = '0;
            else
                r.count = COUNT_W'($urandom_range(cap, 1));
        end else if (pick < 83) begin
            r.op = OP_FREE;
            idx  = $urandom_range(granted_runs.size() - 1);
            g    = granted_runs[idx];
            granted_runs.delete(idx);
            // sometimes give back only the front half and keep the rest
            if (g.count > 1 && $urandom_range(4) == 0) begin
                granted_runs.push_back('{g.start + g.count / 2, g.count - g.count / 2});
                g.count = g.count / 2;
            end
            r.page     = base_reg + PAGE_W'(g.start);
            r.count    = COUNT_W'(g.count);
            last_freed = g;
            have_last  = 1'b1;
        end else begin
            r.op = OP_FREE;
            case ($urandom_range(3))
                0: begin
                    r.count = COUNT_W'($urandom_range(1024));
                end
                1: begin
                    r.page  = base_reg + PAGE_W'($urandom_range(lim + 2));
                    r.count = COUNT_W'($urandom_range(lim + 2));
                end
                2: begin
                    r.page  = base_reg - 1'b1;
                    r.count = COUNT_W'($urandom_range(4));
                end
                default: begin
                    r.page  = base_reg + PAGE_W'(have_last ? last_freed.start : 0);
                    r.count = COUNT_W'(have_last ? last_freed.count : 0);
                end
            endcase
        end
        return r;
    endfunction

    task automatic queue_req(input logic op, input int count, input logic [PAGE_W-1:0] page);
        request_q.push_back('{op, COUNT_W'(count), page});
    endtask

    // register write; the caller is to issue it only while the block is idle, the task does not enforce it
    task automatic write_reg(input logic idx, input logic [PAGE_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BASE)
            base_reg = val;
        else
            pages_reg = val[COUNT_W-1:0];
    endtask

    // wait until every queued request went in and every result word came out
    task automatic drain();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_valid || owed_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers request words, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        request_t nxt;
        bit       offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                owed_results.push_back(serve_request('{s_op, s_page_count, s_page_number}));
            // a stalled word keeps its payload; otherwise maybe take the next
            if (!(s_valid && !s_ready)) begin
                offer = request_q.size() != 0 && (no_idle || $urandom_range(99) >= 6);
                if (offer) begin
                    nxt           = request_q.pop_front();
                    s_op          <= nxt.op;
                    s_page_count  <= nxt.count;
                    s_page_number <= nxt.page;
                end
                s_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, one long stall, in-order checking
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_results
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("result word with no request outstanding");
                end else begin
                    want = owed_results.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch($sformatf("result %0d: status %0d, want %0d",
                                                results_seen, m_status, want.status));
                    if (m_first_page !== want.first)
                        flag_mismatch($sformatf("result %0d: first_page %h, want %h",
                                                results_seen, m_first_page, want.first));
                end
                results_seen++;
            end
            // long stall while the sender keeps offering: the block backs up
            if (!held_once && results_seen >= HOLD_AT && s_valid) begin
                held_once = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || $urandom_range(99) >= 6;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        logic [PAGE_W-1:0]  phase_base  [PHASES];
        logic [COUNT_W-1:0] phase_pages [PHASES];
        logic [PAGE_W-1:0]  top_base;

        // phase 0 random base full pool, 1 single page, 2 base near the top
        // so returned pages wrap, 3 shrink, 4 grow at the largest base,
        // 5 random size, 6 one word plus one page, 7 back to the reset shape
        phase_base[0] = rand36();       phase_pages[0] = 11'd1024;
        phase_base[1] = '0;             phase_pages[1] = 11'd1;
        phase_base[2] = 36'hF_FFFF_FE00; phase_pages[2] = 11'd700;
        phase_base[3] = rand36();       phase_pages[3] = 11'd100;
        phase_base[4] = '1;             phase_pages[4] = 11'd1024;
        phase_base[5] = rand36();       phase_pages[5] = COUNT_W'($urandom_range(1024, 1));
        phase_base[6] = rand36();       phase_pages[6] = 11'd33;
        phase_base[7] = '0;             phase_pages[7] = 11'd1024;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset shape: zero count, whole pool, full map,
        // double free, zero count at the end, past the end, far off
        write_reg(CFG_BASE, '0);
        write_reg(CFG_PAGES, 36'd1024);
        @(negedge aclk);
        queue_req(OP_ALLOC, 0, '0);
        queue_req(OP_ALLOC, 1024, '1);
        queue_req(OP_ALLOC, 1, '0);
        queue_req(OP_FREE, 1, 36'd0);
        queue_req(OP_FREE, 1, 36'd0);
        queue_req(OP_FREE, 1023, 36'd1);
        queue_req(OP_FREE, 0, 36'd1024);
        queue_req(OP_FREE, 0, 36'd1025);
        queue_req(OP_FREE, 25, 36'd1000);
        queue_req(OP_FREE, 0, 36'd5);
        queue_req(OP_FREE, 1024, '1);
        // first fit: a one-page hole is skipped by a two-page request
        queue_req(OP_ALLOC, 1, '0);
        queue_req(OP_ALLOC, 3, '0);
        queue_req(OP_FREE, 1, 36'd0);
        queue_req(OP_ALLOC, 2, '0);
        queue_req(OP_ALLOC, 1, '0);
        queue_req(OP_FREE, 6, 36'd0);
        drain();

        // directed, small pool near the top of the page space: count above
        // the pool, wrapped page number, frees below the base
        top_base = 36'hF_FFFF_FFF0;
        write_reg(CFG_BASE, top_base);
        write_reg(CFG_PAGES, 36'd33);
        @(negedge aclk);
        queue_req(OP_ALLOC, 34, '0);
        queue_req(OP_ALLOC, 32, '0);
        queue_req(OP_ALLOC, 1, '0);
        queue_req(OP_ALLOC, 1, '0);
        queue_req(OP_FREE, 1, 36'h10);
        queue_req(OP_FREE, 1, top_base - 1'b1);
        queue_req(OP_FREE, 32, top_base);
        queue_req(OP_FREE, 33, top_base);
        drain();

        // random phases; the map carries over from one size to the next
        for (int ph = 0; ph < PHASES; ph++) begin
            no_idle = (ph == 2);
            write_reg(CFG_BASE, phase_base[ph]);
            write_reg(CFG_PAGES, PAGE_W'(phase_pages[ph]));
            @(negedge aclk);
            for (int b = 0; b < BATCHES; b++) begin
                for (int n = 0; n < BATCH_LEN; n++)
                    request_q.push_back(make_request());
                drain();
            end
        end
        no_idle = 1'b0;

        // let any stray result word show up before the verdict
        repeat (100) @(posedge aclk);
        if (owed_results.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived", owed_results.size()));
        if (mismatch_cnt == 0)
            $display("contiguous_page_bitmap_allocator_core regression: pass");
        else
            $display("contiguous_page_bitmap_allocator_core regression: fail");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("contiguous_page_bitmap_allocator_core regression: fail");
        $finish;
    end

endmodule : tb_top
